FILE: sv/rhc_pkg.sv
// Shared constants and the cell-to-cell record of the colour converter.
package rhc_pkg;

	localparam int FB = 16;
	localparam int W  = FB + 1;
	localparam int DW = FB + 4;
	localparam int RW = FB + 5;
	localparam int NCELLS = W;

	localparam logic [W-1:0] ONE = {1'b1, {FB{1'b0}}};

	localparam logic MODE_TO_HSV = 1'b0;
	localparam logic MODE_TO_RGB = 1'b1;

	typedef struct packed {
		logic          mode;
		logic          hzero;
		logic          szero;
		logic [DW-1:0] div_s;
		logic [DW-1:0] div_h;
		logic [RW-1:0] rem_s;
		logic [RW-1:0] rem_h;
		logic [W-1:0]  q_s;
		logic [W-1:0]  q_h;
		logic [W-1:0]  res0;
		logic [W-1:0]  res1;
		logic [W-1:0]  res2;
	} cell_t;

endpackage

FILE: sv/rhc_front.sv
// Front stages: saturation, channel extremes, hue sectors and the HSV to RGB products.
module rhc_front import rhc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_vld,
	input  logic         mode,
	input  logic [W-1:0] first_comp,
	input  logic [W-1:0] second_comp,
	input  logic [W-1:0] third_comp,
	output logic         out_vld,
	output cell_t        out_cell
);

	logic          vld_s1, vld_s2;
	logic          mode_s1, mode_s2;
	logic [W-1:0]  a_s1, b_s1, c_s1;
	logic [2:0]    sec_s1, sec_s2;
	logic [FB-1:0] f_s1;
	logic [W-1:0]  a_sat, b_sat, c_sat;
	logic [DW-1:0] h6;

	logic [W-1:0]  mx, mn, d;
	logic [DW-1:0] num6;
	logic signed [RW-1:0] nr, ng, nb, nd, n6, num;
	logic [2*W-1:0] sf, sn, pv;
	logic [W-1:0]  mx_s2, d_s2, c_s2, sfh_s2, snh_s2, p_s2;
	logic [DW-1:0] num6_s2, num_s2;
	logic          szero_s2;

	logic [2*W-1:0] qv, tv;
	logic [W-1:0]  q, t;
	cell_t         nxt;

	assign a_sat = (first_comp  > ONE) ? ONE : first_comp;
	assign b_sat = (second_comp > ONE) ? ONE : second_comp;
	assign c_sat = (third_comp  > ONE) ? ONE : third_comp;
	assign h6 = ({3'b000, a_sat} << 2) + ({3'b000, a_sat} << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a_s1    <= a_sat;
			b_s1    <= b_sat;
			c_s1    <= c_sat;
			sec_s1  <= h6[DW-2:FB];
			f_s1    <= h6[FB-1:0];
		end
	end

	always_comb begin
		mx = a_s1;
		mn = a_s1;
		if (b_s1 > mx) mx = b_s1;
		if (c_s1 > mx) mx = c_s1;
		if (b_s1 < mn) mn = b_s1;
		if (c_s1 < mn) mn = c_s1;
		d = mx - mn;
		num6 = ({3'b000, d} << 2) + ({3'b000, d} << 1);
		nr = $signed({{(RW-W){1'b0}}, a_s1});
		ng = $signed({{(RW-W){1'b0}}, b_s1});
		nb = $signed({{(RW-W){1'b0}}, c_s1});
		nd = $signed({{(RW-W){1'b0}}, d});
		n6 = $signed({1'b0, num6});
		if (a_s1 == mx) begin
			num = ng - nb;
		end else if (b_s1 == mx) begin
			num = (nd <<< 1) + nb - nr;
		end else begin
			num = (nd <<< 2) + nr - ng;
		end
		if (num < 0) num = num + n6;
	end

	assign sf = b_s1 * {1'b0, f_s1};
	assign sn = b_s1 * (ONE - {1'b0, f_s1});
	assign pv = c_s1 * (ONE - b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			mx_s2    <= mx;
			d_s2     <= d;
			num6_s2  <= num6;
			num_s2   <= num[DW-1:0];
			c_s2     <= c_s1;
			sfh_s2   <= sf[FB+W-1:FB];
			snh_s2   <= sn[FB+W-1:FB];
			p_s2     <= pv[FB+W-1:FB];
			szero_s2 <= (b_s1 == '0);
			sec_s2   <= sec_s1;
		end
	end

	assign qv = c_s2 * (ONE - sfh_s2);
	assign tv = c_s2 * (ONE - snh_s2);
	assign q  = qv[FB+W-1:FB];
	assign t  = tv[FB+W-1:FB];

	always_comb begin
		nxt = '0;
		nxt.mode = mode_s2;
		if (mode_s2 == MODE_TO_HSV) begin
			nxt.hzero = (d_s2 == '0);
			nxt.szero = (mx_s2 == '0);
			nxt.div_s = {3'b000, mx_s2};
			nxt.rem_s = {4'b0000, d_s2};
			nxt.div_h = num6_s2;
			nxt.rem_h = {1'b0, num_s2};
			nxt.res2  = mx_s2;
		end else if (szero_s2) begin
			nxt.res0 = c_s2;
			nxt.res1 = c_s2;
			nxt.res2 = c_s2;
		end else begin
			case (sec_s2)
				3'd0: begin nxt.res0 = c_s2; nxt.res1 = t;    nxt.res2 = p_s2; end
				3'd1: begin nxt.res0 = q;    nxt.res1 = c_s2; nxt.res2 = p_s2; end
				3'd2: begin nxt.res0 = p_s2; nxt.res1 = c_s2; nxt.res2 = t;    end
				3'd3: begin nxt.res0 = p_s2; nxt.res1 = q;    nxt.res2 = c_s2; end
				3'd4: begin nxt.res0 = t;    nxt.res1 = p_s2; nxt.res2 = c_s2; end
				default: begin nxt.res0 = c_s2; nxt.res1 = p_s2; nxt.res2 = q; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cell <= nxt;
		end
	end

endmodule

FILE: sv/rhc_div_cell.sv
// One restoring division cell: a quotient bit for saturation and one for hue.
module rhc_div_cell import rhc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  cell_t in_cell,
	output logic  out_vld,
	output cell_t out_cell
);

	logic          ge_s, ge_h;
	logic [RW-1:0] rs, rh;
	cell_t         nxt;

	always_comb begin
		ge_s = in_cell.rem_s >= {1'b0, in_cell.div_s};
		ge_h = in_cell.rem_h >= {1'b0, in_cell.div_h};
		rs = ge_s ? in_cell.rem_s - {1'b0, in_cell.div_s} : in_cell.rem_s;
		rh = ge_h ? in_cell.rem_h - {1'b0, in_cell.div_h} : in_cell.rem_h;
		nxt = in_cell;
		nxt.rem_s = rs << 1;
		nxt.rem_h = rh << 1;
		nxt.q_s = {in_cell.q_s[W-2:0], ge_s};
		nxt.q_h = {in_cell.q_h[W-2:0], ge_h};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cell <= nxt;
		end
	end

endmodule

FILE: sv/rgb_hsv_color_converter.sv
// Top level of the RGB to HSV and HSV to RGB pixel converter.
// Input channel: in_valid, in_ready, mode and three 17-bit components with
// 16 fractional bits; mode 0 converts RGB to HSV, mode 1 HSV to RGB.
// Output channel: out_valid, out_ready and the three result components.
// One beat is accepted per clock while the output does not stall; throughput is one pixel per cycle.
// From an accepted input beat to its output beat a pixel passes through
// three front stages, seventeen division cells (one quotient bit each, the
// quotient width sets the count) and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken; while the receiver stalls with a result waiting,
// in_ready is low and every stage holds its contents.
// Reset clears all valid flags, so the pipeline starts empty.
// Components above 1.0 are clamped to 1.0 on entry.
// Black and grey RGB give hue zero; zero saturation gives grey RGB.
module rgb_hsv_color_converter import rhc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         mode,
	input  logic [W-1:0] first_comp,
	input  logic [W-1:0] second_comp,
	input  logic [W-1:0] third_comp,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_first,
	output logic [W-1:0] out_second,
	output logic [W-1:0] out_third
);

	logic  en;
	logic  vld [NCELLS+1];
	cell_t cel [NCELLS+1];
	cell_t last;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	rhc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_valid),
		.mode        (mode),
		.first_comp  (first_comp),
		.second_comp (second_comp),
		.third_comp  (third_comp),
		.out_vld     (vld[0]),
		.out_cell    (cel[0])
	);

	for (genvar k = 0; k < NCELLS; k++) begin : g_cell
		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld[k]),
			.in_cell  (cel[k]),
			.out_vld  (vld[k+1]),
			.out_cell (cel[k+1])
		);
	end

	assign last = cel[NCELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld[NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.mode == MODE_TO_RGB) begin
				out_first  <= last.res0;
				out_second <= last.res1;
			end else begin
				out_first  <= last.hzero ? '0 : last.q_h;
				out_second <= last.szero ? '0 : last.q_s;
			end
			out_third <= last.res2;
		end
	end

endmodule

FILE: sv/rhc_checker.sv
// Port-level checks of the colour converter and their binding to the top level.
module rhc_checker import rhc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_first,
	input logic [W-1:0] out_second,
	input logic [W-1:0] out_third
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first))
		else $error("stalled result beat changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output space");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_first <= ONE && out_second <= ONE && out_third <= ONE)
		else $error("result component above one");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_first  (out_first),
	.out_second (out_second),
	.out_third  (out_third)
);

FILE: dv/tb.sv
// Self-checking testbench for the RGB and HSV pixel converter, with a directed table and random beats.
`timescale 1ns / 100ps

module tb;
	import rhc_pkg::*;

	typedef struct {
		logic         m;
		logic [W-1:0] a, b, c;
		logic         known;
		logic [W-1:0] ea, eb, ec;
	} row_t;

	typedef struct packed {
		logic [W-1:0] f0, f1, f2;
	} pixel_t;

	localparam int N_RAND = 1900;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_TO_HSV;
	logic [W-1:0] first_comp = '0, second_comp = '0, third_comp = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [W-1:0] out_first, out_second, out_third;

	pixel_t pending_pixels[$];
	int mismatches = 0;
	int beats_in = 0, beats_out = 0;
	int rx_wait = 0;
	longint cycles = 0;

	rgb_hsv_color_converter dut (.*);

	always #4 clk = ~clk;

	function automatic longint unsigned clamp_one(logic [W-1:0] x);
		return (x > ONE) ? longint'(ONE) : longint'(x);
	endfunction

	function automatic pixel_t convert_pixel(logic m, logic [W-1:0] ia, ib, ic);
		longint unsigned r, g, bl, mx, mn, d, sixd, h6, sec, f, p, q, t, u;
		longint signed num;
		pixel_t o;
		r = clamp_one(ia);
		g = clamp_one(ib);
		bl = clamp_one(ic);
		u = longint'(ONE);
		o = '{0, 0, 0};
		if (m == MODE_TO_HSV) begin
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (bl > mx) mx = bl;
			if (g < mn) mn = g;
			if (bl < mn) mn = bl;
			if (mx == 0) return o;
			d = mx - mn;
			o.f2 = W'(mx);
			o.f1 = W'((d * u) / mx);
			if (d == 0) return o;
			if (r == mx) num = longint'(g) - longint'(bl);
			else if (g == mx) num = 2 * longint'(d) + longint'(bl) - longint'(r);
			else num = 4 * longint'(d) + longint'(r) - longint'(g);
			sixd = 6 * d;
			if (num < 0) num += longint'(sixd);
			o.f0 = W'((longint'(num) * u) / sixd);
		end else begin
			if (g == 0) begin
				o.f0 = W'(bl); o.f1 = W'(bl); o.f2 = W'(bl);
				return o;
			end
			h6 = r * 6;
			sec = h6 >> FB;
			f = h6 & (u - 1);
			p = (bl * (u - g)) >> FB;
			q = (bl * (u - ((g * f) >> FB))) >> FB;
			t = (bl * (u - ((g * (u - f)) >> FB))) >> FB;
			case (sec)
				0: begin o.f0 = W'(bl); o.f1 = W'(t); o.f2 = W'(p); end
				1: begin o.f0 = W'(q); o.f1 = W'(bl); o.f2 = W'(p); end
				2: begin o.f0 = W'(p); o.f1 = W'(bl); o.f2 = W'(t); end
				3: begin o.f0 = W'(p); o.f1 = W'(q); o.f2 = W'(bl); end
				4: begin o.f0 = W'(t); o.f1 = W'(p); o.f2 = W'(bl); end
				default: begin o.f0 = W'(bl); o.f1 = W'(p); o.f2 = W'(q); end
			endcase
		end
		return o;
	endfunction

	task automatic send_beat(logic m, logic [W-1:0] ia, ib, ic, bit known, pixel_t typed);
		int gap;
		pixel_t e;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		e = convert_pixel(m, ia, ib, ic);
		if (known && e != typed) begin
			$display("table row disagrees with predictor: %0h %0h %0h", ia, ib, ic);
			mismatches++;
		end
		in_valid <= 1'b1;
		mode <= m;
		first_comp <= ia;
		second_comp <= ib;
		third_comp <= ic;
		pending_pixels.push_back(known ? typed : e);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_in++;
	endtask

	function automatic logic [W-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE;
			2: return W'($urandom_range(ONE + 1, (1 << W) - 1));
			3: return W'($urandom_range(0, 255));
			default: return W'($urandom_range(0, ONE));
		endcase
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			beats_out++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %0h %0h %0h",
					out_first, out_second, out_third);
			end else begin
				pixel_t e;
				e = pending_pixels.pop_front();
				if (out_first !== e.f0 || out_second !== e.f1 || out_third !== e.f2) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0h %0h %0h, got %0h %0h %0h",
							e.f0, e.f1, e.f2, out_first, out_second, out_third);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) rx_wait = $urandom_range(0, 4);
			else if (rx_wait > 0) rx_wait--;
			out_ready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[rgb_hsv_color_converter] ERROR");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[$];
		int wait_cycles;
		logic [W-1:0] h;
		dir_rows = '{
			'{MODE_TO_HSV, 0, 0, 0, 1, 0, 0, 0},
			'{MODE_TO_HSV, ONE, ONE, ONE, 1, 0, 0, ONE},
			'{MODE_TO_HSV, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1, 0, 0, ONE},
			'{MODE_TO_HSV, ONE, 0, 0, 1, 0, ONE, ONE},
			'{MODE_TO_HSV, 0, ONE, 0, 1, 21845, ONE, ONE},
			'{MODE_TO_HSV, 0, 0, ONE, 1, 43690, ONE, ONE},
			'{MODE_TO_HSV, ONE, 0, ONE, 0, 0, 0, 0},
			'{MODE_TO_HSV, ONE, ONE, 0, 0, 0, 0, 0},
			'{MODE_TO_HSV, 0, ONE, ONE, 0, 0, 0, 0},
			'{MODE_TO_HSV, 1, 0, 0, 0, 0, 0, 0},
			'{MODE_TO_HSV, 100, 300, 200, 0, 0, 0, 0},
			'{MODE_TO_HSV, 32768, 32768, 32768, 1, 0, 0, 32768},
			'{MODE_TO_RGB, 0, 0, 0, 1, 0, 0, 0},
			'{MODE_TO_RGB, 12345, 0, 40000, 1, 40000, 40000, 40000},
			'{MODE_TO_RGB, 0, ONE, ONE, 1, ONE, 0, 0},
			'{MODE_TO_RGB, ONE, ONE, ONE, 1, ONE, 0, ONE},
			'{MODE_TO_RGB, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1, ONE, 0, ONE},
			'{MODE_TO_RGB, 10923, ONE, ONE, 0, 0, 0, 0},
			'{MODE_TO_RGB, 21846, 30000, 50000, 0, 0, 0, 0},
			'{MODE_TO_RGB, 32768, 1, ONE, 0, 0, 0, 0},
			'{MODE_TO_RGB, 43691, ONE, 1, 0, 0, 0, 0},
			'{MODE_TO_RGB, 54614, 50000, ONE, 0, 0, 0, 0},
			'{MODE_TO_RGB, 65535, ONE, ONE, 0, 0, 0, 0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].m, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
				dir_rows[i].known, '{dir_rows[i].ea, dir_rows[i].eb, dir_rows[i].ec});
		in_valid <= 1'b0;
		// Drain the pipeline completely before the random beats begin.
		while (pending_pixels.size() != 0) @(posedge clk);
		for (int i = 0; i < N_RAND; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				h = W'($urandom_range(0, 5) * 10923 + $urandom_range(0, 3) - 1);
				send_beat(MODE_TO_RGB, h, rand_comp(), rand_comp(), 0, '{0, 0, 0});
			end else
				send_beat(logic'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
					0, '{0, 0, 0});
		end
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 60) begin
			@(posedge clk);
			wait_cycles++;
		end
		$display("Covered %0d beats in, %0d beats out: both conversion modes, clamped,", beats_in,
			beats_out);
		$display("black, grey, sector-edge and random pixels under random stalls on both sides.");
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("[rgb_hsv_color_converter] OK");
		else
			$display("[rgb_hsv_color_converter] ERROR");
		$finish;
	end
endmodule

FILE: rgb_hsv_color_converter.f
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_div_cell.sv
sv/rgb_hsv_color_converter.sv
sv/rhc_checker.sv
dv/tb.sv
